// ===== rtl/trc_pkg.sv =====
// trc_pkg: shared types and constants of the two-field range classifier.
// Used by trc_front, trc_queue, trc_back and two_field_range_classifier.
// No dependencies.
package trc_pkg;

  localparam int ADDR_W        = 32;  // address and bound width
  localparam int POS_W         = 7;   // rule_index field width
  localparam int COUNT_OUT_W   = 7;   // rule_count field width
  localparam int MATCH_W       = 6;   // match_index field width
  localparam int MAX_RULES_DEF = 64;  // default table depth
  localparam int Q_DEPTH       = 2;   // front-to-back queue depth
  localparam int Q_PTR_W       = 1;   // index width of that queue

  typedef enum logic [1:0] {
    CMD_CLASSIFY = 2'd0,
    CMD_INSERT   = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src_low;
    logic [ADDR_W-1:0] src_high;
    logic [ADDR_W-1:0] dst_low;
    logic [ADDR_W-1:0] dst_high;
  } rule_t;

  // One decoded word on its way from front to back.
  typedef struct packed {
    cmd_t              cmd;
    status_t           status;
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    rule_t             rule;
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_MOVE,
    B_PLACE,
    B_REPORT
  } back_state_t;

endpackage

// ===== rtl/trc_front.sv =====
// trc_front: accepts input words, checks insert/remove against its own
// rule count and hands decoded ops to the queue. Depends on trc_pkg.
module trc_front #(
  parameter int MAX_RULES = trc_pkg::MAX_RULES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 command,
  input  logic [trc_pkg::ADDR_W-1:0] src_addr,
  input  logic [trc_pkg::ADDR_W-1:0] dst_addr,
  input  logic [trc_pkg::POS_W-1:0]  rule_index,
  input  logic [trc_pkg::ADDR_W-1:0] src_low,
  input  logic [trc_pkg::ADDR_W-1:0] src_high,
  input  logic [trc_pkg::ADDR_W-1:0] dst_low,
  input  logic [trc_pkg::ADDR_W-1:0] dst_high,
  input  logic                       q_full,
  output logic                       q_push,
  output trc_pkg::op_t               q_op
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int CMP_W = (CNT_W > trc_pkg::POS_W) ? CNT_W : trc_pkg::POS_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_cmp;
  logic [CMP_W-1:0] count_cmp;
  trc_pkg::cmd_t    cmd;
  trc_pkg::status_t status;

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;
  assign cmd        = trc_pkg::cmd_t'(command);
  assign pos_cmp    = CMP_W'(rule_index);
  assign count_cmp  = CMP_W'(count);

  always_comb begin
    status     = trc_pkg::ST_OK;
    count_next = count;
    unique case (cmd)
      trc_pkg::CMD_CLASSIFY: begin
        count_next = count;
      end
      trc_pkg::CMD_INSERT: begin
        // position check wins over the full check
        if (pos_cmp > count_cmp) begin
          status = trc_pkg::ST_RANGE;
        end else if (count == CNT_W'(MAX_RULES)) begin
          status = trc_pkg::ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      trc_pkg::CMD_REMOVE: begin
        if (pos_cmp >= count_cmp) begin
          status = trc_pkg::ST_RANGE;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      trc_pkg::CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_comb begin
    q_op               = '0;
    q_op.cmd           = cmd;
    q_op.status        = status;
    q_op.pos           = rule_index;
    q_op.src_addr      = src_addr;
    q_op.dst_addr      = dst_addr;
    q_op.rule.src_low  = src_low;
    q_op.rule.src_high = src_high;
    q_op.rule.dst_low  = dst_low;
    q_op.rule.dst_high = dst_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/trc_queue.sv =====
// trc_queue: two-entry FIFO of decoded ops between front and back.
// Depends on trc_pkg.
module trc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  trc_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output trc_pkg::op_t head_op
);

  localparam int CNT_W = $clog2(trc_pkg::Q_DEPTH + 1);

  trc_pkg::op_t              entries [trc_pkg::Q_DEPTH];
  logic [trc_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [trc_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]            fill;

  assign full       = (fill == CNT_W'(trc_pkg::Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + trc_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + trc_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/trc_back.sv =====
// trc_back: rule memory plus sequencer that scans, shifts and writes it,
// and the result register. Depends on trc_pkg.
module trc_back #(
  parameter int MAX_RULES = trc_pkg::MAX_RULES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  trc_pkg::op_t                    q_op,
  output logic                            q_pop,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      status,
  output logic                            match_found,
  output logic [trc_pkg::MATCH_W-1:0]     match_index,
  output logic [trc_pkg::COUNT_OUT_W-1:0] rule_count
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CMP_W = ((CNT_W > trc_pkg::POS_W) ? CNT_W : trc_pkg::POS_W) + 1;

  trc_pkg::rule_t rule_mem [MAX_RULES];
  trc_pkg::rule_t rd_data;

  trc_pkg::back_state_t state;
  trc_pkg::back_state_t state_next;
  trc_pkg::op_t         cur;
  logic [CNT_W-1:0]     rules_held;
  logic [CNT_W-1:0]     rules_held_next;
  logic [IDX_W-1:0]     ptr;
  logic [IDX_W-1:0]     last;
  logic                 issue_on;
  logic                 pend;
  logic [IDX_W-1:0]     pend_idx;
  logic                 found;
  logic [IDX_W-1:0]     hit_idx;

  logic                 issue;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  trc_pkg::rule_t       wr_data;
  logic                 load_res;
  logic                 res_free;
  logic                 hit;
  logic                 scan_end;
  logic                 move_end;
  logic [IDX_W-1:0]     q_pos;
  logic [IDX_W-1:0]     held_last;
  logic [IDX_W-1:0]     start;
  logic [IDX_W-1:0]     last_init;
  logic                 q_ok;
  logic                 ins_moves;
  logic                 rem_moves;

  assign res_free  = !result_valid || !result_stall;
  assign q_pos     = IDX_W'(q_op.pos);
  assign held_last = IDX_W'(rules_held - CNT_W'(1));
  assign q_ok      = (q_op.status == trc_pkg::ST_OK);
  assign ins_moves = CMP_W'(rules_held) > CMP_W'(q_op.pos);
  assign rem_moves = (CMP_W'(q_op.pos) + CMP_W'(1)) < CMP_W'(rules_held);

  assign hit = (cur.src_addr >= rd_data.src_low) && (cur.src_addr <= rd_data.src_high) &&
               (cur.dst_addr >= rd_data.dst_low) && (cur.dst_addr <= rd_data.dst_high);
  assign scan_end = pend && (hit || (pend_idx == last));
  assign move_end = pend && (pend_idx == last);

  // scan walks up from 0; insert shifts from the top down; remove from pos+1 up
  always_comb begin
    start           = '0;
    last_init       = held_last;
    rules_held_next = rules_held;
    unique case (q_op.cmd)
      trc_pkg::CMD_CLASSIFY: begin
        start     = '0;
        last_init = held_last;
      end
      trc_pkg::CMD_INSERT: begin
        start     = held_last;
        last_init = q_pos;
        if (q_ok) begin
          rules_held_next = rules_held + CNT_W'(1);
        end
      end
      trc_pkg::CMD_REMOVE: begin
        start     = q_pos + IDX_W'(1);
        last_init = held_last;
        if (q_ok) begin
          rules_held_next = rules_held - CNT_W'(1);
        end
      end
      trc_pkg::CMD_CLEAR: begin
        rules_held_next = '0;
      end
      default: begin
        rules_held_next = rules_held;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      trc_pkg::B_IDLE: begin
        if (q_valid) begin
          unique case (q_op.cmd)
            trc_pkg::CMD_CLASSIFY: begin
              state_next = (rules_held != '0) ? trc_pkg::B_SCAN : trc_pkg::B_REPORT;
            end
            trc_pkg::CMD_INSERT: begin
              if (!q_ok) begin
                state_next = trc_pkg::B_REPORT;
              end else begin
                state_next = ins_moves ? trc_pkg::B_MOVE : trc_pkg::B_PLACE;
              end
            end
            trc_pkg::CMD_REMOVE: begin
              state_next = (q_ok && rem_moves) ? trc_pkg::B_MOVE : trc_pkg::B_REPORT;
            end
            trc_pkg::CMD_CLEAR: begin
              state_next = trc_pkg::B_REPORT;
            end
            default: begin
              state_next = trc_pkg::B_REPORT;
            end
          endcase
        end
      end
      trc_pkg::B_SCAN: begin
        if (scan_end) begin
          state_next = trc_pkg::B_REPORT;
        end
      end
      trc_pkg::B_MOVE: begin
        if (move_end) begin
          state_next = (cur.cmd == trc_pkg::CMD_INSERT) ? trc_pkg::B_PLACE
                                                        : trc_pkg::B_REPORT;
        end
      end
      trc_pkg::B_PLACE: begin
        state_next = trc_pkg::B_REPORT;
      end
      trc_pkg::B_REPORT: begin
        if (res_free) begin
          state_next = trc_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = trc_pkg::B_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    issue    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = pend_idx;
    wr_data  = rd_data;
    load_res = 1'b0;
    unique case (state)
      trc_pkg::B_IDLE: begin
        q_pop = q_valid;
      end
      trc_pkg::B_SCAN: begin
        issue = issue_on;
      end
      trc_pkg::B_MOVE: begin
        issue   = issue_on;
        wr_en   = pend;
        wr_addr = (cur.cmd == trc_pkg::CMD_INSERT) ? pend_idx + IDX_W'(1)
                                                   : pend_idx - IDX_W'(1);
        wr_data = rd_data;
      end
      trc_pkg::B_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(cur.pos);
        wr_data = cur.rule;
      end
      trc_pkg::B_REPORT: begin
        load_res = res_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // rule memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem[wr_addr] <= wr_data;
    end
    rd_data <= rule_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= trc_pkg::B_IDLE;
      rules_held   <= '0;
      issue_on     <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        rules_held <= rules_held_next;
        issue_on   <= 1'b1;
        pend       <= 1'b0;
      end else begin
        pend <= issue;
        if (issue && (ptr == last)) begin
          issue_on <= 1'b0;
        end
      end
      if (load_res) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_op;
      ptr     <= start;
      last    <= last_init;
      found   <= 1'b0;
      hit_idx <= '0;
    end else begin
      if (issue) begin
        pend_idx <= ptr;
        if ((state == trc_pkg::B_MOVE) && (cur.cmd == trc_pkg::CMD_INSERT)) begin
          ptr <= ptr - IDX_W'(1);
        end else begin
          ptr <= ptr + IDX_W'(1);
        end
      end
      if ((state == trc_pkg::B_SCAN) && pend && hit) begin
        found   <= 1'b1;
        hit_idx <= pend_idx;
      end
    end
    if (load_res) begin
      status      <= cur.status;
      match_found <= found;
      match_index <= trc_pkg::MATCH_W'(hit_idx);
      rule_count  <= trc_pkg::COUNT_OUT_W'(rules_held);
    end
  end

endmodule

// ===== rtl/two_field_range_classifier.sv =====
// two_field_range_classifier: top level; front, queue and back wired together.
// Depends on trc_pkg, trc_front, trc_queue, trc_back.
//
// Ordered table of up to MAX_RULES rules, each an inclusive source range and
// an inclusive destination range. A classify word returns the lowest rule
// index whose ranges hold both addresses; insert and remove shift the rules
// above the position; clear empties the table. The front checks every word
// against its own rule count and queues it (two entries), so input words are
// taken while the back is still busy. The back works one word at a time on a
// rule memory with one write and one registered read port, one rule per cycle.
// Classify scans the held rules from 0 up to the first hit; insert moves
// the rules from the top down to pos, then writes the new rule; remove
// moves the rules above pos down one place; clear and a refused word only
// report. The memory sweep is what sets the rate. Results wait in an output
// register.
module two_field_range_classifier #(
  parameter int MAX_RULES = trc_pkg::MAX_RULES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      command,
  input  logic [trc_pkg::ADDR_W-1:0]      src_addr,
  input  logic [trc_pkg::ADDR_W-1:0]      dst_addr,
  input  logic [trc_pkg::POS_W-1:0]       rule_index,
  input  logic [trc_pkg::ADDR_W-1:0]      src_low,
  input  logic [trc_pkg::ADDR_W-1:0]      src_high,
  input  logic [trc_pkg::ADDR_W-1:0]      dst_low,
  input  logic [trc_pkg::ADDR_W-1:0]      dst_high,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      status,
  output logic                            match_found,
  output logic [trc_pkg::MATCH_W-1:0]     match_index,
  output logic [trc_pkg::COUNT_OUT_W-1:0] rule_count
);

  // front -> queue
  logic         q_full;
  logic         q_push;
  trc_pkg::op_t push_op;
  // queue -> back
  logic         q_pop;
  logic         head_valid;
  trc_pkg::op_t head_op;

  trc_front #(
    .MAX_RULES (MAX_RULES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .src_addr   (src_addr),
    .dst_addr   (dst_addr),
    .rule_index (rule_index),
    .src_low    (src_low),
    .src_high   (src_high),
    .dst_low    (dst_low),
    .dst_high   (dst_high),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (push_op)
  );

  trc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  trc_back #(
    .MAX_RULES (MAX_RULES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (head_valid),
    .q_op         (head_op),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .match_found  (match_found),
    .match_index  (match_index),
    .rule_count   (rule_count)
  );

endmodule
